// File: sv/miller_rabin_primality_test_unit_macros.svh
// Assertion macros for the Miller-Rabin primality test unit.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef MILLER_RABIN_PRIMALITY_TEST_UNIT_MACROS_SVH
`define MILLER_RABIN_PRIMALITY_TEST_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// The antecedent implies the consequent in the same cycle.
`define MRPT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// The antecedent implies the consequent in the next cycle.
`define MRPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define MRPT_ASSERT_IMPL(lbl, ante, cons)
`define MRPT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/mrpt_pkg.sv
// Shared constants and types of the Miller-Rabin primality test unit.
// Depends on nothing.
package mrpt_pkg;

  localparam int NUMBER_WIDTH = 63;
  localparam int CNT_W        = $clog2(NUMBER_WIDTH);
  localparam int IN_DATA_W    = ((2 * NUMBER_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W   = 8;

  typedef logic [NUMBER_WIDTH-1:0] num_t;

  // Status of the shared modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// File: sv/miller_rabin_primality_test_unit.sv
// Miller-Rabin primality test unit: one witness round per input beat.
// One in_ beat carries candidate p, witness a and, on tlast, the final-round mark.
// Candidates below 2 and even candidates other than 2 fail at once; 2 passes.
// Otherwise the witness is reduced mod p bit-serially (N = 63 bits), p-1 is
// split into d*2^r one bit per cycle, y = a^d mod p is formed by square and
// multiply, and up to r-1 further squarings look for p-1.
// Every modular product goes through one shared bit-serial multiplier, which sets
// the rate; trivial candidates and a witness that reduces to zero end the round early.
// One round is worked on at a time: in_tready is high only while idle.
// A failed round sets a sticky composite flag. A beat with tlast produces one
// out_ beat, is_probable_prime = 1 when no round of the test failed, and clears
// the flag; other beats produce no output.
// The verdict waits in an output register, so a new round is accepted while it
// is held; a final round that completes while out_tready is still low waits
// until the earlier verdict is taken.
// Reset (rst_n low at a clock edge) clears the flag and any pending verdict.
// Depends on mrpt_pkg, mrpt_modmul and the macro header.
`include "miller_rabin_primality_test_unit_macros.svh"
module miller_rabin_primality_test_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // candidate [62:0], witness [125:63], zero fill above
  input  logic [mrpt_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // is_probable_prime [0], zero fill above
  output logic [mrpt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mrpt_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_REDUCE = 4'd2;
  localparam logic [3:0] S_ZERO   = 4'd3;
  localparam logic [3:0] S_SPLIT  = 4'd4;
  localparam logic [3:0] S_POW    = 4'd5;
  localparam logic [3:0] S_MULA   = 4'd6;
  localparam logic [3:0] S_MULB   = 4'd7;
  localparam logic [3:0] S_TEST   = 4'd8;
  localparam logic [3:0] S_SQW    = 4'd9;
  localparam logic [3:0] S_SQCHK  = 4'd10;
  localparam logic [3:0] S_FINISH = 4'd11;

  logic [3:0]       state_r, state_nxt;
  num_t             p_r, p_nxt;
  num_t             wsh_r, wsh_nxt;
  num_t             rem_r, rem_nxt;
  num_t             d_r, d_nxt;
  num_t             y_r, y_nxt;
  num_t             base_r, base_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] r_r, r_nxt;
  logic             last_r, last_nxt;
  logic             fail_r, fail_nxt;
  logic             composite_r, composite_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             verdict_r, verdict_nxt;

  num_t                  pm1;
  logic [NUMBER_WIDTH:0] trial;
  logic                  emit;
  logic                  mul_start;
  num_t                  mul_a, mul_b, mul_prod;
  mul_stat_t             mul_stat;

  mrpt_modmul u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .modulus (p_r),
    .stat    (mul_stat),
    .product (mul_prod)
  );

  assign pm1       = p_r - 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign trial     = {rem_r, wsh_r[NUMBER_WIDTH-1]};
  assign emit      = (state_r == S_FINISH) && last_r && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    wsh_nxt       = wsh_r;
    rem_nxt       = rem_r;
    d_nxt         = d_r;
    y_nxt         = y_r;
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    r_nxt         = r_r;
    last_nxt      = last_r;
    fail_nxt      = fail_r;
    composite_nxt = composite_r;
    verdict_nxt   = verdict_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mul_start     = 1'b0;
    mul_a         = y_r;
    mul_b         = y_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          p_nxt     = in_tdata[NUMBER_WIDTH-1:0];
          wsh_nxt   = in_tdata[2*NUMBER_WIDTH-1:NUMBER_WIDTH];
          last_nxt  = in_tlast;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        rem_nxt = '0;
        cnt_nxt = '0;
        d_nxt   = pm1;
        r_nxt   = '0;
        if (p_r == NUMBER_WIDTH'(2)) begin
          fail_nxt  = 1'b0;
          state_nxt = S_FINISH;
        end else if (p_r[NUMBER_WIDTH-1:1] == '0 || !p_r[0]) begin
          fail_nxt  = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_REDUCE;
        end
      end
      // Restoring reduction of the witness, most significant bit first.
      S_REDUCE: begin
        if (trial >= {1'b0, p_r}) begin
          rem_nxt = NUMBER_WIDTH'(trial - {1'b0, p_r});
        end else begin
          rem_nxt = trial[NUMBER_WIDTH-1:0];
        end
        wsh_nxt = wsh_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUMBER_WIDTH - 1)) begin
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        if (rem_r == '0) begin
          fail_nxt  = 1'b0;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          r_nxt = r_r + 1'b1;
        end else begin
          y_nxt     = NUMBER_WIDTH'(1);
          base_nxt  = rem_r;
          state_nxt = S_POW;
        end
      end
      S_POW: begin
        if (d_r == '0) begin
          state_nxt = S_TEST;
        end else if (d_r[0]) begin
          mul_start = 1'b1;
          mul_a     = y_r;
          mul_b     = base_r;
          state_nxt = S_MULA;
        end else begin
          mul_start = 1'b1;
          mul_a     = base_r;
          mul_b     = base_r;
          state_nxt = S_MULB;
        end
      end
      S_MULA: begin
        if (mul_stat.done) begin
          y_nxt = mul_prod;
          // The last exponent bit needs no further squaring of the base.
          if (d_r[NUMBER_WIDTH-1:1] == '0) begin
            d_nxt     = '0;
            state_nxt = S_POW;
          end else begin
            mul_start = 1'b1;
            mul_a     = base_r;
            mul_b     = base_r;
            state_nxt = S_MULB;
          end
        end
      end
      S_MULB: begin
        if (mul_stat.done) begin
          base_nxt  = mul_prod;
          d_nxt     = d_r >> 1;
          state_nxt = S_POW;
        end
      end
      S_TEST, S_SQCHK: begin
        if (y_r == pm1 || (state_r == S_TEST && y_r == NUMBER_WIDTH'(1))) begin
          fail_nxt  = 1'b0;
          state_nxt = S_FINISH;
        end else if (y_r == NUMBER_WIDTH'(1) || r_r == CNT_W'(1)) begin
          fail_nxt  = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          mul_start = 1'b1;
          r_nxt     = r_r - 1'b1;
          state_nxt = S_SQW;
        end
      end
      S_SQW: begin
        if (mul_stat.done) begin
          y_nxt     = mul_prod;
          state_nxt = S_SQCHK;
        end
      end
      S_FINISH: begin
        if (!last_r) begin
          composite_nxt = composite_r | fail_r;
          state_nxt     = S_IDLE;
        end else if (emit) begin
          verdict_nxt   = !(composite_r | fail_r);
          out_valid_nxt = 1'b1;
          composite_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    wsh_r     <= wsh_nxt;
    rem_r     <= rem_nxt;
    d_r       <= d_nxt;
    y_r       <= y_nxt;
    base_r    <= base_nxt;
    cnt_r     <= cnt_nxt;
    r_r       <= r_nxt;
    last_r    <= last_nxt;
    fail_r    <= fail_nxt;
    verdict_r <= verdict_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      composite_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      composite_r <= composite_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 1){1'b0}}, verdict_r};

  `MRPT_ASSERT_IMPL(a_idle_mul_quiet, in_tready, !mul_stat.busy)
  `MRPT_ASSERT_IMPL(a_done_when_waiting, mul_stat.done, state_r == S_MULA || state_r == S_MULB || state_r == S_SQW)
  `MRPT_ASSERT_IMPL(a_rem_below_p, state_r == S_ZERO, rem_r < p_r)
  `MRPT_ASSERT_NEXT(a_verdict_clears, emit, out_tvalid && !composite_r)

endmodule

// File: sv/mrpt_modmul.sv
// Bit-serial modular multiplier: product = a * b mod m, one bit of b per cycle.
// Depends on mrpt_pkg.
module mrpt_modmul (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  mrpt_pkg::num_t   mul_a,
  input  mrpt_pkg::num_t   mul_b,
  input  mrpt_pkg::num_t   modulus,
  output mrpt_pkg::mul_stat_t stat,
  output mrpt_pkg::num_t   product
);
  import mrpt_pkg::*;

  num_t             a_r, a_nxt;
  num_t             b_r, b_nxt;
  num_t             acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  // Both operands are below the modulus, so the sum fits one extra bit.
  function automatic num_t add_mod(input num_t x, input num_t y, input num_t m);
    logic [NUMBER_WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[NUMBER_WIDTH-1:0];
  endfunction

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = mul_a;
      b_nxt    = mul_b;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = add_mod(acc_r, a_r, modulus);
      end
      a_nxt   = add_mod(a_r, a_r, modulus);
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUMBER_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = acc_r;

endmodule
